// ===== design/bcs_pkg.sv =====
// Package: widths, register indexes, reset values and payload types of the basis solver.
`timescale 1ns / 1ps
`default_nettype none
package bcs_pkg;

  localparam int FRAC_BITS = 16;

  localparam int COMP_W = 20;                      // basis component, Q4.FRAC_BITS
  localparam int VEC_W  = 32;                      // vector component, Q16.FRAC_BITS
  localparam int REG_W  = 3 * COMP_W;              // packed basis register
  localparam int IDX_W  = 2;

  localparam int MIN_W  = 2 * COMP_W + 1;          // 2x2 minor of basis components
  localparam int OMIN_W = VEC_W + COMP_W + 1;      // 2x2 minor with one vector row
  localparam int DET_W  = COMP_W + MIN_W;          // determinant, signed
  localparam int DMAG_W = DET_W - 1;               // determinant magnitude
  localparam int NUM_W  = VEC_W + MIN_W;           // numerator, signed
  localparam int NMAG_W = NUM_W - 1;               // numerator magnitude
  localparam int XW     = NMAG_W + FRAC_BITS;      // scaled dividend
  localparam int QB     = VEC_W + 2;               // quotient bits kept
  localparam int RW     = (XW > DMAG_W + QB) ? XW : DMAG_W + QB;

  typedef enum logic [IDX_W-1:0] {
    REG_FIRST  = 2'd0,
    REG_SECOND = 2'd1,
    REG_THIRD  = 2'd2
  } reg_idx_e;

  localparam logic [REG_W-1:0] RST_FIRST  = REG_W'(1) << FRAC_BITS;
  localparam logic [REG_W-1:0] RST_SECOND = REG_W'(1) << (FRAC_BITS + COMP_W);
  localparam logic [REG_W-1:0] RST_THIRD  = REG_W'(1) << (FRAC_BITS + 2 * COMP_W);

  typedef struct packed {
    logic signed [VEC_W-1:0] vec_x;
    logic signed [VEC_W-1:0] vec_y;
    logic signed [VEC_W-1:0] vec_z;
  } vec_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] coord_first;
    logic signed [VEC_W-1:0] coord_second;
    logic signed [VEC_W-1:0] coord_third;
    logic                    singular;
    logic                    saturated;
  } coord_t;

  // Basis components plus values derived from them
  typedef struct packed {
    logic signed [COMP_W-1:0] i0;
    logic signed [COMP_W-1:0] i1;
    logic signed [COMP_W-1:0] i2;
    logic signed [COMP_W-1:0] j0;
    logic signed [COMP_W-1:0] j1;
    logic signed [COMP_W-1:0] j2;
    logic signed [COMP_W-1:0] k0;
    logic signed [COMP_W-1:0] k1;
    logic signed [COMP_W-1:0] k2;
    logic signed [MIN_W-1:0]  mjk;
    logic signed [MIN_W-1:0]  mik;
    logic signed [MIN_W-1:0]  mij;
    logic [DMAG_W-1:0]        dmag;
    logic                     dneg;
    logic                     dzero;
  } basis_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] n0;
    logic signed [NUM_W-1:0] n1;
    logic signed [NUM_W-1:0] n2;
  } num_t;

endpackage
`default_nettype wire

// ===== design/bcs_basis.sv =====
// Basis registers and the minors and determinant derived from them.
`timescale 1ns / 1ps
`default_nettype none
module bcs_basis
  import bcs_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  input  wire logic [IDX_W-1:0] cfg_index_i,
  input  wire logic [REG_W-1:0] cfg_data_i,
  output basis_t                basis_o
);

  logic [REG_W-1:0] first_q, second_q, third_q;
  logic signed [MIN_W-1:0] mjk_q, mik_q, mij_q;
  logic signed [DET_W-1:0] det_q;
  logic [DMAG_W-1:0] dmag_q;
  logic dneg_q, dzero_q;
  basis_t b;

  // Write the addressed register, drop unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= RST_FIRST;
      second_q <= RST_SECOND;
      third_q  <= RST_THIRD;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FIRST:  first_q  <= cfg_data_i;
        REG_SECOND: second_q <= cfg_data_i;
        REG_THIRD:  third_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Unpack components
  always_comb begin
    b       = '0;
    b.i0    = first_q[COMP_W-1:0];
    b.i1    = first_q[2*COMP_W-1:COMP_W];
    b.i2    = first_q[3*COMP_W-1:2*COMP_W];
    b.j0    = second_q[COMP_W-1:0];
    b.j1    = second_q[2*COMP_W-1:COMP_W];
    b.j2    = second_q[3*COMP_W-1:2*COMP_W];
    b.k0    = third_q[COMP_W-1:0];
    b.k1    = third_q[2*COMP_W-1:COMP_W];
    b.k2    = third_q[3*COMP_W-1:2*COMP_W];
    b.mjk   = mjk_q;
    b.mik   = mik_q;
    b.mij   = mij_q;
    b.dmag  = dmag_q;
    b.dneg  = dneg_q;
    b.dzero = dzero_q;
  end

  assign basis_o = b;

  // Minors over rows one and two
  logic signed [2*COMP_W-1:0] p_jk, p_kj, p_ik, p_ki, p_ij, p_ji;
  assign p_jk = b.j1 * b.k2;
  assign p_kj = b.k1 * b.j2;
  assign p_ik = b.i1 * b.k2;
  assign p_ki = b.k1 * b.i2;
  assign p_ij = b.i1 * b.j2;
  assign p_ji = b.j1 * b.i2;

  always_ff @(posedge clk_i) begin
    mjk_q <= MIN_W'(p_jk) - MIN_W'(p_kj);
    mik_q <= MIN_W'(p_ik) - MIN_W'(p_ki);
    mij_q <= MIN_W'(p_ij) - MIN_W'(p_ji);
  end

  // Determinant by expansion along row zero
  logic signed [DET_W-1:0] d0, d1, d2;
  assign d0 = b.i0 * mjk_q;
  assign d1 = b.j0 * mik_q;
  assign d2 = b.k0 * mij_q;

  always_ff @(posedge clk_i) begin
    det_q <= d0 - d1 + d2;
  end

  // Sign, magnitude and zero test
  logic signed [DET_W-1:0] det_neg;
  assign det_neg = -det_q;

  always_ff @(posedge clk_i) begin
    dneg_q  <= det_q[DET_W-1];
    dzero_q <= (det_q == '0);
    dmag_q  <= det_q[DET_W-1] ? det_neg[DMAG_W-1:0] : det_q[DMAG_W-1:0];
  end

endmodule
`default_nettype wire

// ===== design/bcs_numer.sv =====
// Numerator pipeline: vector minors, products and the three Cramer numerators.
`timescale 1ns / 1ps
`default_nettype none
module bcs_numer
  import bcs_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   en_i,
  input  wire vec_t   vec_i,
  input  wire basis_t basis_i,
  output num_t        num_o
);

  vec_t s1_q;
  logic signed [VEC_W-1:0]  o0_q;
  logic signed [OMIN_W-1:0] a_q, b_q, c_q;
  logic signed [NUM_W-1:0]  t00_q, t01_q, t02_q, t10_q, t11_q, t12_q, t20_q, t21_q, t22_q;
  num_t num_q;

  // Capture the input vector
  always_ff @(posedge clk_i) begin
    if (en_i) s1_q <= vec_i;
  end

  // Minors that carry a vector row
  logic signed [OMIN_W-2:0] pa1, pa2, pb1, pb2, pc1, pc2;
  assign pa1 = s1_q.vec_y * basis_i.k2;
  assign pa2 = basis_i.k1 * s1_q.vec_z;
  assign pb1 = s1_q.vec_y * basis_i.j2;
  assign pb2 = basis_i.j1 * s1_q.vec_z;
  assign pc1 = s1_q.vec_y * basis_i.i2;
  assign pc2 = basis_i.i1 * s1_q.vec_z;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      o0_q <= s1_q.vec_x;
      a_q  <= OMIN_W'(pa1) - OMIN_W'(pa2);
      b_q  <= OMIN_W'(pb1) - OMIN_W'(pb2);
      c_q  <= OMIN_W'(pc1) - OMIN_W'(pc2);
    end
  end

  // Nine row-zero products, one register each
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t00_q <= NUM_W'(o0_q * basis_i.mjk);
      t01_q <= NUM_W'(basis_i.j0 * a_q);
      t02_q <= NUM_W'(basis_i.k0 * b_q);
      t10_q <= NUM_W'(basis_i.i0 * a_q);
      t11_q <= NUM_W'(o0_q * basis_i.mik);
      t12_q <= NUM_W'(basis_i.k0 * c_q);
      t20_q <= NUM_W'(basis_i.i0 * b_q);
      t21_q <= NUM_W'(basis_i.j0 * c_q);
      t22_q <= NUM_W'(o0_q * basis_i.mij);
    end
  end

  // Sum into numerators
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q.n0 <= t00_q - t01_q + t02_q;
      num_q.n1 <= t10_q - t11_q - t12_q;
      num_q.n2 <= t21_q - t20_q + t22_q;
    end
  end

  assign num_o = num_q;

endmodule
`default_nettype wire

// ===== design/bcs_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, scaled numerator over |D|.
`timescale 1ns / 1ps
`default_nettype none
module bcs_div
  import bcs_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire logic signed [NUM_W-1:0] num_i,
  input  wire logic [DMAG_W-1:0]       dmag_i,
  input  wire logic                    dneg_i,
  output logic [QB-1:0]                q_o,
  output logic                         neg_o
);

  logic [RW-1:0] rem_q [QB];
  logic [QB-1:0] q_q   [QB+1];
  logic          neg_q [QB+1];

  // Take magnitude and scale by the fraction
  logic              nneg;
  logic signed [NUM_W-1:0] nflip;
  logic [NMAG_W-1:0] nmag;
  assign nneg  = num_i[NUM_W-1];
  assign nflip = -num_i;
  assign nmag  = nneg ? nflip[NMAG_W-1:0] : num_i[NMAG_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= RW'(nmag) << FRAC_BITS;
      q_q[0]   <= '0;
      neg_q[0] <= nneg ^ dneg_i;
    end
  end

  // Compare and subtract, highest quotient bit first
  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int B = QB - 1 - k;
    logic [RW-1:0] dsh;
    logic          ge;
    assign dsh = RW'(dmag_i) << B;
    assign ge  = (rem_q[k] >= dsh);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[k+1]   <= q_q[k] | (QB'(ge) << B);
        neg_q[k+1] <= neg_q[k];
      end
    end

    if (k < QB - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) rem_q[k+1] <= ge ? rem_q[k] - dsh : rem_q[k];
      end
    end
  end

  assign q_o   = q_q[QB];
  assign neg_o = neg_q[QB];

endmodule
`default_nettype wire

// ===== design/basis_coordinate_solver_3x3_unit.sv =====
// Top level: basis solver by Cramer's rule, numerator pipeline, three dividers, clamp.
//
//  channel | signals                           | direction
//  --------+-----------------------------------+----------
//  in      | in_valid_i in_ready_o in_data_i   | vector in
//  out     | out_valid_o out_ready_i out_data_o| coords out
//  cfg     | cfg_valid_i cfg_ready_o cfg_index_i cfg_data_i | register write
//
// One transaction per cycle while no result is held; the one-bit-per-stage dividers sit
// behind a four-stage numerator pipeline.
// Reset restores the unit basis and empties the pipeline; no clearing pass.
// A held result freezes every stage together; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module basis_coordinate_solver_3x3_unit
  import bcs_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire vec_t             in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output coord_t                out_data_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [IDX_W-1:0] cfg_index_i,
  input  wire logic [REG_W-1:0] cfg_data_i
);

  localparam int NSTG = QB + 6;

  basis_t basis;
  num_t   num;
  logic   en;
  logic [NSTG-1:0] vld_q;
  logic [QB-1:0] q0, q1, q2;
  logic neg0, neg1, neg2;
  coord_t out_q, out_d;

  assign cfg_ready_o = 1'b1;

  // Advance all stages unless the result is held
  assign en          = !vld_q[NSTG-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[NSTG-1];
  assign out_data_o  = out_q;

  bcs_basis u_basis (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .basis_o     (basis)
  );

  bcs_numer u_numer (
    .clk_i   (clk_i),
    .en_i    (en),
    .vec_i   (in_data_i),
    .basis_i (basis),
    .num_o   (num)
  );

  bcs_div u_div0 (
    .clk_i (clk_i), .en_i (en), .num_i (num.n0),
    .dmag_i (basis.dmag), .dneg_i (basis.dneg), .q_o (q0), .neg_o (neg0)
  );

  bcs_div u_div1 (
    .clk_i (clk_i), .en_i (en), .num_i (num.n1),
    .dmag_i (basis.dmag), .dneg_i (basis.dneg), .q_o (q1), .neg_o (neg1)
  );

  bcs_div u_div2 (
    .clk_i (clk_i), .en_i (en), .num_i (num.n2),
    .dmag_i (basis.dmag), .dneg_i (basis.dneg), .q_o (q2), .neg_o (neg2)
  );

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], in_valid_i};
    end
  end

  // Apply sign and clamp one quotient
  function automatic logic [VEC_W:0] clamp(input logic [QB-1:0] q, input logic neg);
    logic sat;
    logic [VEC_W-1:0] v;
    logic [VEC_W-1:0] mag;
    mag = q[VEC_W-1:0];
    if (neg) begin
      sat = (q[QB-1:VEC_W] != '0) || (q[VEC_W-1] && (q[VEC_W-2:0] != '0));
      v   = sat ? {1'b1, {(VEC_W-1){1'b0}}} : (~mag + VEC_W'(1));
    end else begin
      sat = (q[QB-1:VEC_W-1] != '0);
      v   = sat ? {1'b0, {(VEC_W-1){1'b1}}} : mag;
    end
    return {sat, v};
  endfunction

  // Build the result, forcing zeros on a singular basis
  logic [VEC_W:0] c0, c1, c2;
  always_comb begin
    c0 = clamp(q0, neg0);
    c1 = clamp(q1, neg1);
    c2 = clamp(q2, neg2);
    out_d = '0;
    if (basis.dzero) begin
      out_d.singular = 1'b1;
    end else begin
      out_d.coord_first  = c0[VEC_W-1:0];
      out_d.coord_second = c1[VEC_W-1:0];
      out_d.coord_third  = c2[VEC_W-1:0];
      out_d.saturated    = c0[VEC_W] | c1[VEC_W] | c2[VEC_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= out_d;
  end

`ifndef SYNTHESIS
  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.singular |->
      out_data_o.coord_first == '0 && out_data_o.coord_second == '0 &&
      out_data_o.coord_third == '0 && !out_data_o.saturated)
    else $error("singular result with nonzero coordinates");

  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.saturated |->
      out_data_o.coord_first == 32'h7FFFFFFF || out_data_o.coord_first == 32'h80000000 ||
      out_data_o.coord_second == 32'h7FFFFFFF || out_data_o.coord_second == 32'h80000000 ||
      out_data_o.coord_third == 32'h7FFFFFFF || out_data_o.coord_third == 32'h80000000)
    else $error("saturated flag without a clamped coordinate");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted transaction missing from first stage");
`endif

endmodule
`default_nettype wire
